>>> design/wmmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmf_pkg: shared types and constants
// register indexes, mode values and sequencer states used by the core
// ----------------------------------------------------------------------------
package wmmf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COORD_W  = 10;
	localparam int SIZE_W   = 11;
	localparam int RAD_W    = 3;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_T   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Z = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_T = 3'd7;

	localparam logic MODE_MIN = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_HOLD
	} walk_state_t;

endpackage

>>> design/wmmf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmf_store: circular sample store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module wmmf_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [wmmf_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [AW-1:0]                     rd_addr,
	output logic signed [wmmf_pkg::SAMPLE_W-1:0] rd_data
);

	logic signed [wmmf_pkg::SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/window_min_max_filter_4d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_min_max_filter_4d_top: streaming 4-D box min / max filter
// each completing word walks N = (2rx+1)(2ry+1)(2rz+1)(2rt+1) window entries,
//   store reads at one a cycle; no walk when the window span reaches the store depth
// throughput: one word per cycle while s_tready is high; after a completing word
//   input waits until the result is taken, and after a register write until strides settle
// reset: arst_n clears counters, pointer and registers; store is not cleared
// ----------------------------------------------------------------------------
module window_min_max_filter_4d_top #(
	parameter int CHANNELS    = 1,
	parameter int STORE_DEPTH = 65536,
	parameter int MAX_EXTENT  = 1024,
	parameter int MAX_RADIUS  = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // sample
	input  logic        s_tlast,  // last_of_volume
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // value, out_x, out_y, out_z, out_t, out_channel
	output logic        m_tuser   // span_error
);

	localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int AP  = AW + 1;
	localparam int CW  = 2;
	localparam int SW  = wmmf_pkg::SAMPLE_W;
	localparam int XW  = wmmf_pkg::COORD_W;
	localparam int LW  = 48;
	localparam logic [2:0] SETTLE_CYC = 3'd5;

	// configuration registers
	logic        mode_q;
	logic [10:0] size_y_q, size_z_q, size_t_q;
	logic [2:0]  rad_x_q, rad_y_q, rad_z_q, rad_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wmmf_pkg::MODE_MIN;
			size_y_q <= 11'd1; size_z_q <= 11'd1; size_t_q <= 11'd1;
			rad_x_q <= '0; rad_y_q <= '0; rad_z_q <= '0; rad_t_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmmf_pkg::REG_MODE:     mode_q   <= cfg_data[0];
				wmmf_pkg::REG_SIZE_Y:   size_y_q <= cfg_data;
				wmmf_pkg::REG_SIZE_Z:   size_z_q <= cfg_data;
				wmmf_pkg::REG_SIZE_T:   size_t_q <= cfg_data;
				wmmf_pkg::REG_RADIUS_X: rad_x_q  <= cfg_data[2:0];
				wmmf_pkg::REG_RADIUS_Y: rad_y_q  <= cfg_data[2:0];
				wmmf_pkg::REG_RADIUS_Z: rad_z_q  <= cfg_data[2:0];
				wmmf_pkg::REG_RADIUS_T: rad_t_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// hold off input while the derived strides settle after a write
	logic [2:0] settle_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYC;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYC;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	// effective sizes and radii
	function automatic logic [12:0] eff_size(input logic [10:0] v);
		logic [12:0] r;
		r = {2'b0, v};
		if (v == '0) r = 13'd1;
		else if (32'(v) > MAX_EXTENT) r = 13'(MAX_EXTENT);
		return r;
	endfunction

	function automatic logic [3:0] eff_rad(input logic [2:0] v);
		logic [3:0] r;
		r = {1'b0, v};
		if (32'(v) > MAX_RADIUS) r = 4'(MAX_RADIUS);
		return r;
	endfunction

	// twice a small radius times a stride, by shift and add
	function automatic logic [LW-1:0] scale2(input logic [3:0] k, input logic [LW-1:0] s);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < 4; i++)
			if (k[i]) r = r + (s << (i + 1));
		return r;
	endfunction

	logic [12:0] sy, sz, st;
	logic [3:0]  rx, ry, rz, rt;
	assign sy = eff_size(size_y_q);
	assign sz = eff_size(size_z_q);
	assign st = eff_size(size_t_q);
	assign rx = eff_rad(rad_x_q);
	assign ry = eff_rad(rad_y_q);
	assign rz = eff_rad(rad_z_q);
	assign rt = eff_rad(rad_t_q);

	// strides, registered one per product; window wraps, steps and span follow
	logic [LW-1:0] str_t_q, str_z_q, str_y_q, str_x_q;
	logic [LW-1:0] wrap_t_q, wrap_z_q, wrap_y_q, wrap_x_q;
	logic [LW-1:0] step_z_q, step_y_q, step_x_q, span_q;
	always_ff @(posedge clk) begin
		str_t_q <= LW'(CHANNELS);
		str_z_q <= LW'(str_t_q[23:0] * 24'(st));
		str_y_q <= LW'(str_z_q[31:0] * 16'(sz));
		str_x_q <= LW'(str_y_q[31:0] * 16'(sy));
		wrap_t_q <= scale2(rt, str_t_q);
		wrap_z_q <= scale2(rz, str_z_q);
		wrap_y_q <= scale2(ry, str_y_q);
		wrap_x_q <= scale2(rx, str_x_q);
		step_z_q <= str_z_q - wrap_t_q;
		step_y_q <= str_y_q - wrap_t_q - wrap_z_q;
		step_x_q <= str_x_q - wrap_t_q - wrap_z_q - wrap_y_q;
		span_q <= wrap_t_q + wrap_z_q + wrap_y_q + wrap_x_q;
	end

	// position counters and write pointer
	logic [CW-1:0] pos_c_q;
	logic [12:0]   pos_t_q, pos_z_q, pos_y_q, pos_x_q;
	logic [AW-1:0] wp_q;

	// walker state
	wmmf_pkg::walk_state_t state_q, state_d;
	logic [3:0] bx_q, by_q, bz_q, bt_q;
	logic [LW-1:0] back_q;
	logic [AW-1:0] base_q, rd_addr;
	logic [AW:0]   rd_diff;
	logic signed [SW-1:0] acc_q, rd_data;
	logic last_rd_q, rd_pend_q, walk_done;
	logic [XW-1:0] ox_q, oy_q, oz_q, ot_q;
	logic [CW-1:0] oc_q;
	logic          oerr_q;
	logic          out_full_q;

	logic s_acc, completes, span_err;
	assign s_acc = s_tvalid && s_tready;
	assign completes = pos_x_q >= 13'({rx, 1'b0}) && pos_y_q >= 13'({ry, 1'b0}) &&
		pos_y_q < sy && pos_z_q >= 13'({rz, 1'b0}) && pos_z_q < sz &&
		pos_t_q >= 13'({rt, 1'b0}) && pos_t_q < st;
	assign span_err = span_q >= LW'(STORE_DEPTH);

	assign s_tready = (state_q == wmmf_pkg::ST_IDLE) && !out_full_q && (settle_q == '0);

	// store
	wmmf_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk(clk), .wr_en(s_acc), .wr_addr(wp_q), .wr_data(s_tdata),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	// circular read address, wraps below entry zero
	assign rd_diff = {1'b0, base_q} - AP'(back_q);
	assign rd_addr = rd_diff[AW] ? AW'(rd_diff + AP'(STORE_DEPTH)) : rd_diff[AW-1:0];

	assign walk_done = bt_q == {rt[2:0], 1'b0} && bz_q == {rz[2:0], 1'b0} &&
		by_q == {ry[2:0], 1'b0} && bx_q == {rx[2:0], 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmmf_pkg::ST_IDLE: if (s_acc && completes && !span_err)
				state_d = wmmf_pkg::ST_WALK;
			wmmf_pkg::ST_WALK: if (walk_done) state_d = wmmf_pkg::ST_DRAIN;
			wmmf_pkg::ST_DRAIN: if (!rd_pend_q) state_d = wmmf_pkg::ST_HOLD;
			wmmf_pkg::ST_HOLD: state_d = wmmf_pkg::ST_IDLE;
			default: state_d = wmmf_pkg::ST_IDLE;
		endcase
	end

	// stride for the innermost step with carries
	logic [LW-1:0] back_nx;
	always_comb begin
		back_nx = back_q + str_t_q;
		if (bt_q == {rt[2:0], 1'b0}) begin
			back_nx = back_q + step_z_q;
			if (bz_q == {rz[2:0], 1'b0}) begin
				back_nx = back_q + step_y_q;
				if (by_q == {ry[2:0], 1'b0})
					back_nx = back_q + step_x_q;
			end
		end
	end

	logic signed [SW-1:0] init_v;
	assign init_v = (mode_q == wmmf_pkg::MODE_MAX) ? 16'sh8000 : 16'sh7fff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmmf_pkg::ST_IDLE;
			pos_c_q <= '0; pos_t_q <= '0; pos_z_q <= '0; pos_y_q <= '0; pos_x_q <= '0;
			wp_q <= '0;
			rd_pend_q <= 1'b0;
			last_rd_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_pend_q <= (state_q == wmmf_pkg::ST_WALK);
			last_rd_q <= (state_q == wmmf_pkg::ST_WALK) && walk_done;
			if (m_tvalid && m_tready) out_full_q <= 1'b0;
			if (state_q == wmmf_pkg::ST_HOLD) out_full_q <= 1'b1;
			if (s_acc) begin
				wp_q <= (32'(wp_q) == STORE_DEPTH - 1) ? '0 : wp_q + 1'b1;
				if (completes && span_err) out_full_q <= 1'b1;
				if (s_tlast) begin
					pos_c_q <= '0; pos_t_q <= '0; pos_z_q <= '0;
					pos_y_q <= '0; pos_x_q <= '0;
				end else if (32'(pos_c_q) + 1 < CHANNELS) begin
					pos_c_q <= pos_c_q + 1'b1;
				end else begin
					pos_c_q <= '0;
					if (pos_t_q + 13'd1 < st) pos_t_q <= pos_t_q + 13'd1;
					else begin
						pos_t_q <= '0;
						if (pos_z_q + 13'd1 < sz) pos_z_q <= pos_z_q + 13'd1;
						else begin
							pos_z_q <= '0;
							if (pos_y_q + 13'd1 < sy) pos_y_q <= pos_y_q + 13'd1;
							else begin
								pos_y_q <= '0;
								pos_x_q <= (32'(pos_x_q) + 1 < MAX_EXTENT) ?
									pos_x_q + 13'd1 : '0;
							end
						end
					end
				end
			end
		end
	end

	// walk counters, accumulator and result fields
	always_ff @(posedge clk) begin
		if (s_acc) begin
			base_q <= wp_q;
			back_q <= '0;
			bx_q <= '0; by_q <= '0; bz_q <= '0; bt_q <= '0;
			acc_q <= !span_err ? init_v : '0;
			oerr_q <= span_err;
			ox_q <= XW'(pos_x_q - 13'(rx));
			oy_q <= XW'(pos_y_q - 13'(ry));
			oz_q <= XW'(pos_z_q - 13'(rz));
			ot_q <= XW'(pos_t_q - 13'(rt));
			oc_q <= pos_c_q;
		end else if (state_q == wmmf_pkg::ST_WALK && !walk_done) begin
			back_q <= back_nx;
			if (bt_q == {rt[2:0], 1'b0}) begin
				bt_q <= '0;
				if (bz_q == {rz[2:0], 1'b0}) begin
					bz_q <= '0;
					if (by_q == {ry[2:0], 1'b0}) begin
						by_q <= '0;
						bx_q <= bx_q + 4'd1;
					end else by_q <= by_q + 4'd1;
				end else bz_q <= bz_q + 4'd1;
			end else bt_q <= bt_q + 4'd1;
		end
		if (rd_pend_q) begin
			if (mode_q == wmmf_pkg::MODE_MAX ? (rd_data > acc_q) : (rd_data < acc_q))
				acc_q <= rd_data;
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = {6'b0, oc_q, ot_q, oz_q, oy_q, ox_q, acc_q};
	assign m_tuser  = oerr_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wmmf_pkg::ST_IDLE) |-> !s_tready)
		else $error("input taken during walk");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_rd_q |-> (state_q == wmmf_pkg::ST_DRAIN))
		else $error("walk end out of order");
`endif

endmodule

>>> bench/tb_window_min_max_filter_4d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_min_max_filter_4d_top: self-checking bench for the 4-D min/max filter
// streams voxel words through the filter in phases of fixed register settings;
// a behavioral predictor of the store, the position counters and the window
// walk builds the expected results, which a monitor compares field by field
// ----------------------------------------------------------------------------
module tb_window_min_max_filter_4d_top;

	localparam int DEPTH = 65536;
	localparam int EXTENT = 1024;
	localparam int RADMAX = 7;

	typedef struct packed {
		logic signed [15:0] value;
		logic [9:0] x;
		logic [9:0] y;
		logic [9:0] z;
		logic [9:0] t;
		logic [1:0] ch;
		logic err;
	} window_result_t;

	typedef struct packed {
		logic [15:0] smp;
		logic lst;
	} voxel_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;

	window_min_max_filter_4d_top dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [15:0] voxel_mem [DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned px = 0, py = 0, pz = 0, pt = 0;
	int unsigned r_mode = 0, r_sy = 1, r_sz = 1, r_st = 1;
	int unsigned r_rx = 0, r_ry = 0, r_rz = 0, r_rt = 0;

	voxel_word_t pending_words [$];
	window_result_t expected_results [$];
	bit failed = 1'b0;
	bit quiet = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;

	function automatic int unsigned eff_size(int unsigned v);
		if (v == 0) return 1;
		if (v > EXTENT) return EXTENT;
		return v;
	endfunction

	function automatic int unsigned window_cycles();
		return (2 * r_rx + 1) * (2 * r_ry + 1) * (2 * r_rz + 1) * (2 * r_rt + 1);
	endfunction

	// store the voxel, advance counters, queue a result when a window completes
	function automatic void predict_window(logic [15:0] smp, logic lst);
		int unsigned sy, sz, st;
		longint unsigned span, back;
		int signed best, v;
		window_result_t res;
		sy = eff_size(r_sy);
		sz = eff_size(r_sz);
		st = eff_size(r_st);
		voxel_mem[wr_ptr] = smp;
		if (px >= 2 * r_rx && py >= 2 * r_ry && py < sy && pz >= 2 * r_rz && pz < sz &&
				pt >= 2 * r_rt && pt < st) begin
			span = 2 * r_rt + longint'(st) * (2 * r_rz + longint'(sz) *
				(2 * r_ry + longint'(sy) * (2 * r_rx)));
			best = 0;
			res.err = 1'b0;
			if (span >= DEPTH) begin
				res.err = 1'b1;
			end else begin
				best = (r_mode == wmmf_pkg::MODE_MAX) ? -32768 : 32767;
				for (int bx = 0; bx <= 2 * r_rx; bx++)
					for (int by = 0; by <= 2 * r_ry; by++)
						for (int bz = 0; bz <= 2 * r_rz; bz++)
							for (int bt = 0; bt <= 2 * r_rt; bt++) begin
								back = bt + longint'(st) * (bz + longint'(sz) *
									(by + longint'(sy) * bx));
								v = voxel_mem[(wr_ptr + DEPTH - back) % DEPTH];
								if ((r_mode == wmmf_pkg::MODE_MAX) ? (v > best) : (v < best))
									best = v;
							end
			end
			res.value = best[15:0];
			res.x = 10'(px - r_rx);
			res.y = 10'(py - r_ry);
			res.z = 10'(pz - r_rz);
			res.t = 10'(pt - r_rt);
			res.ch = 2'd0;
			expected_results.push_back(res);
		end
		wr_ptr = (wr_ptr + 1) % DEPTH;
		if (lst) begin
			px = 0; py = 0; pz = 0; pt = 0;
		end else if (pt + 1 < st) begin
			pt++;
		end else begin
			pt = 0;
			if (pz + 1 < sz) begin
				pz++;
			end else begin
				pz = 0;
				if (py + 1 < sy) begin
					py++;
				end else begin
					py = 0;
					px = (px + 1 < EXTENT) ? px + 1 : 0;
				end
			end
		end
	endfunction

	// driver: feeds words from the pending queue with random gaps
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			predict_window(s_tdata, s_tlast);
		if (s_tvalid && !s_tready) begin
			// hold the current word
		end else if (src_gap > 0) begin
			src_gap <= src_gap - 1;
			s_tvalid <= 1'b0;
		end else if (arst_n && pending_words.size() > 0) begin
			voxel_word_t w;
			w = pending_words.pop_front();
			s_tdata <= w.smp;
			s_tlast <= w.lst;
			s_tvalid <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 16);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor: checks each result word and applies random back-pressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word tdata=%h tuser=%b", $time, m_tdata, m_tuser);
				failed = 1'b1;
			end else begin
				window_result_t e;
				e = expected_results.pop_front();
				if (m_tdata[15:0] !== e.value || m_tdata[25:16] !== e.x ||
						m_tdata[35:26] !== e.y || m_tdata[45:36] !== e.z ||
						m_tdata[55:46] !== e.t || m_tdata[57:56] !== e.ch ||
						m_tdata[63:58] !== 6'd0 || m_tuser !== e.err) begin
					$display("%0t: mismatch expected val=%0d x=%0d y=%0d z=%0d t=%0d c=%0d err=%0d",
						$time, e.value, e.x, e.y, e.z, e.t, e.ch, e.err);
					$display("%0t:          actual val=%0d x=%0d y=%0d z=%0d t=%0d c=%0d err=%0d",
						$time, $signed(m_tdata[15:0]), m_tdata[25:16], m_tdata[35:26],
						m_tdata[45:36], m_tdata[55:46], m_tdata[57:56], m_tuser);
					failed = 1'b1;
				end
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 16);
		end
	end

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 11'(val);
		case (idx)
			wmmf_pkg::REG_MODE: r_mode = val & 1;
			wmmf_pkg::REG_SIZE_Y: r_sy = val & 11'h7ff;
			wmmf_pkg::REG_SIZE_Z: r_sz = val & 11'h7ff;
			wmmf_pkg::REG_SIZE_T: r_st = val & 11'h7ff;
			wmmf_pkg::REG_RADIUS_X: r_rx = val & 7;
			wmmf_pkg::REG_RADIUS_Y: r_ry = val & 7;
			wmmf_pkg::REG_RADIUS_Z: r_rz = val & 7;
			default: r_rt = val & 7;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_filter(int unsigned md, int unsigned sy, int unsigned sz, int unsigned st,
			int unsigned rx, int unsigned ry, int unsigned rz, int unsigned rt);
		write_reg(wmmf_pkg::REG_MODE, md);
		write_reg(wmmf_pkg::REG_SIZE_Y, sy);
		write_reg(wmmf_pkg::REG_SIZE_Z, sz);
		write_reg(wmmf_pkg::REG_SIZE_T, st);
		write_reg(wmmf_pkg::REG_RADIUS_X, rx);
		write_reg(wmmf_pkg::REG_RADIUS_Y, ry);
		write_reg(wmmf_pkg::REG_RADIUS_Z, rz);
		write_reg(wmmf_pkg::REG_RADIUS_T, rt);
	endtask

	task automatic push_word(logic [15:0] smp, logic lst);
		voxel_word_t w;
		w.smp = smp;
		w.lst = lst;
		pending_words.push_back(w);
	endtask

	// random volume; the last word closes it so counters restart
	task automatic push_random(int n, int last_odds);
		for (int i = 0; i < n; i++)
			push_word(16'($urandom), (i == n - 1) || (last_odds > 0 &&
				$urandom_range(1, last_odds) == 1));
	endtask

	// wait until every word is in and every result is out, then let a walk finish
	task automatic drain();
		while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (window_cycles() + 10) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes through a 3-wide min, then max
		for (int md = 0; md < 2; md++) begin
			set_filter(md, 1, 1, 1, 1, 0, 0, 0);
			push_word(16'h0005, 1'b0);
			push_word(16'h8000, 1'b0);
			push_word(16'h7fff, 1'b0);
			push_word(16'h0000, 1'b0);
			push_word(16'hffff, 1'b0);
			push_word(16'h8000, 1'b0);
			push_word(16'h0064, 1'b0);
			push_word(16'h7fff, 1'b0);
			push_word(16'hffff, 1'b1);
			drain();
		end

		// zero and oversized extents, full radius along one axis each
		set_filter(0, 0, 2047, 0, 7, 0, 0, 0);
		push_random(20, 0);
		drain();
		set_filter(1, 16, 1, 1, 0, 7, 0, 0);
		push_random(40, 0);
		drain();
		set_filter(0, 1, 15, 2, 0, 0, 7, 0);
		push_random(40, 0);
		drain();
		set_filter(1, 1, 1, 16, 0, 0, 0, 7);
		push_random(40, 0);
		drain();

		// window span reaching the store depth: grow the extents mid volume
		set_filter(0, 1, 1, 1, 1, 0, 0, 0);
		push_word(16'($urandom), 1'b0);
		push_word(16'($urandom), 1'b0);
		drain();
		write_reg(wmmf_pkg::REG_SIZE_Y, 1024);
		write_reg(wmmf_pkg::REG_SIZE_Z, 32);
		push_random(24, 0);
		drain();

		// random settings with small windows
		for (int ph = 0; ph < 6; ph++) begin
			int unsigned sy, sz, st;
			sy = $urandom_range(0, 4);
			sz = $urandom_range(0, 4);
			st = $urandom_range(1, 5);
			if (ph == 5) quiet = 1'b1;
			set_filter($urandom_range(0, 1), sy, sz, st, $urandom_range(0, 2),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 2));
			push_random(40, 60);
			drain();
		end

		repeat (100) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
design/wmmf_pkg.sv
design/wmmf_store.sv
design/window_min_max_filter_4d_top.sv
bench/tb_window_min_max_filter_4d_top.sv
